[hw/rtl/single_wire_uart_8e2_with_break_assert.svh]
// Assertion macros for the single-wire UART block.
`ifndef SINGLE_WIRE_UART_8E2_WITH_BREAK_ASSERT_SVH
`define SINGLE_WIRE_UART_8E2_WITH_BREAK_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define SWU_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("swu assertion failed");
// Antecedent that implies a consequent in the next cycle.
`define SWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swu assertion failed");
`else
`define SWU_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/swu_pkg.sv]
// Shared constants, types and helpers of the single-wire UART block.
package swu_pkg;

    // Width of the phase timers.
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] REG_BIT_TICKS   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [1:0] REG_BREAK_LOW   = 2'd2;
    localparam logic [1:0] REG_BREAK_HIGH  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_BIT_TICKS  = 10'd72;
    localparam logic [23:0] RST_TIMEOUT    = 24'd0;
    localparam logic [23:0] RST_BREAK_LOW  = 24'd360448;
    localparam logic [23:0] RST_BREAK_HIGH = 24'd32768;

    // Request codes.
    localparam logic [2:0] FN_NONE  = 3'd0;
    localparam logic [2:0] FN_TX    = 3'd1;
    localparam logic [2:0] FN_RX    = 3'd2;
    localparam logic [2:0] FN_BRK1  = 3'd3;
    localparam logic [2:0] FN_BRK2  = 3'd4;

    // Phase codes of the sequencer.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_TX_PRE    = 4'd1;
    localparam logic [3:0] PH_TX_START  = 4'd2;
    localparam logic [3:0] PH_TX_DATA   = 4'd3;
    localparam logic [3:0] PH_TX_PARITY = 4'd4;
    localparam logic [3:0] PH_TX_STOP   = 4'd5;
    localparam logic [3:0] PH_TX_TAIL   = 4'd6;
    localparam logic [3:0] PH_RX_WAIT   = 4'd7;
    localparam logic [3:0] PH_RX_HALF   = 4'd8;
    localparam logic [3:0] PH_RX_BITS   = 4'd9;
    localparam logic [3:0] PH_RX_STOP   = 4'd10;
    localparam logic [3:0] PH_BRK_LOW   = 4'd11;
    localparam logic [3:0] PH_BRK_HIGH  = 4'd12;

    // Byte returned when a receive times out.
    localparam logic [7:0] RX_TIMEOUT_BYTE = 8'h80;

    typedef logic [COUNT_W-1:0] t_cnt;

    // One result beat.
    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_timeout;
        logic       tx_done;
    } t_res;

    // Phase length: zero becomes one tick, an overlong value saturates.
    function automatic t_cnt clamp_len(input logic [COUNT_W:0] len);
        t_cnt r;
        if (len == '0) begin
            r = t_cnt'(1);
        end else if (len[COUNT_W]) begin
            r = CNT_MAX;
        end else begin
            r = len[COUNT_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/swu_if.sv]
// Handshake channels of the single-wire UART block: request, result and register write.
interface swu_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       line_in;
    modport source (output valid, func, tx_byte, line_in, input ready);
    modport sink (input valid, func, tx_byte, line_in, output ready);
endinterface

interface swu_out_if;
    logic       valid;
    logic       ready;
    logic       line_out;
    logic       line_drive;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_timeout;
    logic       tx_done;
    modport source (output valid, line_out, line_drive, busy_res, rx_valid, rx_byte,
                    rx_timeout, tx_done, input ready);
    modport sink (input valid, line_out, line_drive, busy_res, rx_valid, rx_byte,
                  rx_timeout, tx_done, output ready);
endinterface

interface swu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [23:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

[hw/rtl/single_wire_uart_8e2_with_break.sv]
// Single-wire half-duplex UART (8 data bits, even parity) with break sequences.
// Each input beat is one bit-timer tick; its result beat is registered and appears in the cycle after acceptance.
// Throughput is one beat per cycle while the result is taken: the tick update is a single pass
// from the sequencer registers to the result register, which also decouples the two channels.
// Synchronous active-low reset returns the sequencer to idle, drops any pending result beat
// and loads the register defaults; register writes are always accepted.
`include "single_wire_uart_8e2_with_break_assert.svh"

module single_wire_uart_8e2_with_break (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swu_in_if.sink        i_in,
    swu_out_if.source     o_out,
    swu_cfg_if.sink       i_cfg
);

    // Configuration registers.
    logic [9:0]  r_bit_ticks;
    logic [23:0] r_timeout;
    logic [23:0] r_brk_low;
    logic [23:0] r_brk_high;

    // Sequencer state.
    logic [3:0]     r_phase,  n_phase;
    swu_pkg::t_cnt  r_tick,   n_tick;
    logic [3:0]     r_bidx,   n_bidx;
    logic [7:0]     r_shift,  n_shift;
    logic           r_parity, n_parity;
    logic           r_brk2,   n_brk2;
    swu_pkg::t_cnt  r_wait,   n_wait;

    // Result register.
    logic           r_ovalid;
    swu_pkg::t_res  r_res,    n_res;

    logic           in_take;
    logic [10:0]    len_pre;
    logic [10:0]    len_2b;
    logic [9:0]     len_half_up;
    logic [9:0]     len_half_dn;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_ovalid || o_out.ready;
    assign in_take     = i_in.valid && i_in.ready;

    // Phase lengths derived from the bit time.
    assign len_half_up = 10'((11'(r_bit_ticks) + 11'd1) >> 1);
    assign len_half_dn = r_bit_ticks >> 1;
    assign len_pre     = 11'(r_bit_ticks) + 11'(len_half_up);
    assign len_2b      = {r_bit_ticks, 1'b0};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks <= swu_pkg::RST_BIT_TICKS;
            r_timeout   <= swu_pkg::RST_TIMEOUT;
            r_brk_low   <= swu_pkg::RST_BREAK_LOW;
            r_brk_high  <= swu_pkg::RST_BREAK_HIGH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.addr)
                swu_pkg::REG_BIT_TICKS:  r_bit_ticks <= i_cfg.data[9:0];
                swu_pkg::REG_TIMEOUT:    r_timeout   <= i_cfg.data;
                swu_pkg::REG_BREAK_LOW:  r_brk_low   <= i_cfg.data;
                swu_pkg::REG_BREAK_HIGH: r_brk_high  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One tick of the sequencer and the result it produces.
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bidx   = r_bidx;
        n_shift  = r_shift;
        n_parity = r_parity;
        n_brk2   = r_brk2;
        n_wait   = r_wait;
        n_res    = '0;

        if (r_phase == swu_pkg::PH_IDLE) begin
            // Requests are only taken from idle; other codes leave it idle.
            if (i_in.func == swu_pkg::FN_TX) begin
                n_shift  = i_in.tx_byte;
                n_parity = ^i_in.tx_byte;
                n_bidx   = '0;
                n_phase  = swu_pkg::PH_TX_PRE;
                n_tick   = swu_pkg::clamp_len(25'(len_pre));
            end else if (i_in.func == swu_pkg::FN_RX) begin
                n_phase = swu_pkg::PH_RX_WAIT;
                n_wait  = '0;
                n_shift = '0;
                n_bidx  = '0;
            end else if (i_in.func == swu_pkg::FN_BRK1 || i_in.func == swu_pkg::FN_BRK2) begin
                n_brk2  = (i_in.func == swu_pkg::FN_BRK2);
                n_phase = swu_pkg::PH_BRK_LOW;
                n_tick  = swu_pkg::clamp_len(25'(r_brk_low));
            end
        end else if (r_phase == swu_pkg::PH_RX_WAIT) begin
            // Start edge search with optional timeout.
            priority if (r_timeout != '0 && r_wait >= r_timeout) begin
                n_phase          = swu_pkg::PH_IDLE;
                n_res.rx_valid   = 1'b1;
                n_res.rx_byte    = swu_pkg::RX_TIMEOUT_BYTE;
                n_res.rx_timeout = 1'b1;
            end else if (!i_in.line_in) begin
                n_phase = swu_pkg::PH_RX_HALF;
                n_tick  = swu_pkg::clamp_len(25'(len_half_dn));
            end else begin
                // The wait counter saturates.
                if (r_wait != swu_pkg::CNT_MAX) begin
                    n_wait = r_wait + 1'b1;
                end
            end
        end else if (r_tick > swu_pkg::t_cnt'(1)) begin
            n_tick = r_tick - 1'b1;
        end else begin
            // Phase timer expired: move to the next phase.
            unique case (r_phase)
                swu_pkg::PH_TX_PRE: begin
                    n_phase = swu_pkg::PH_TX_START;
                    n_tick  = swu_pkg::clamp_len(25'(r_bit_ticks));
                end
                swu_pkg::PH_TX_START: begin
                    n_phase = swu_pkg::PH_TX_DATA;
                    n_bidx  = '0;
                    n_tick  = swu_pkg::clamp_len(25'(r_bit_ticks));
                end
                swu_pkg::PH_TX_DATA: begin
                    n_shift = r_shift >> 1;
                    n_bidx  = r_bidx + 1'b1;
                    if (n_bidx >= 4'd8) begin
                        n_phase = swu_pkg::PH_TX_PARITY;
                    end
                    n_tick = swu_pkg::clamp_len(25'(r_bit_ticks));
                end
                swu_pkg::PH_TX_PARITY: begin
                    n_phase = swu_pkg::PH_TX_STOP;
                    n_tick  = swu_pkg::clamp_len(25'(r_bit_ticks));
                end
                swu_pkg::PH_TX_STOP: begin
                    n_phase = swu_pkg::PH_TX_TAIL;
                    n_tick  = swu_pkg::clamp_len(25'(len_half_up));
                end
                swu_pkg::PH_TX_TAIL: begin
                    n_phase       = swu_pkg::PH_IDLE;
                    n_res.tx_done = 1'b1;
                end
                swu_pkg::PH_RX_HALF: begin
                    n_phase = swu_pkg::PH_RX_BITS;
                    n_bidx  = '0;
                    n_tick  = swu_pkg::clamp_len(25'(r_bit_ticks));
                end
                swu_pkg::PH_RX_BITS: begin
                    n_shift = {i_in.line_in, r_shift[7:1]};
                    n_bidx  = r_bidx + 1'b1;
                    if (n_bidx >= 4'd8) begin
                        n_phase = swu_pkg::PH_RX_STOP;
                        n_tick  = swu_pkg::clamp_len(25'(len_2b));
                    end else begin
                        n_tick = swu_pkg::clamp_len(25'(r_bit_ticks));
                    end
                end
                swu_pkg::PH_RX_STOP: begin
                    n_phase        = swu_pkg::PH_IDLE;
                    n_res.rx_valid = 1'b1;
                    n_res.rx_byte  = r_shift;
                end
                swu_pkg::PH_BRK_LOW: begin
                    n_phase = swu_pkg::PH_BRK_HIGH;
                    n_tick  = swu_pkg::clamp_len(25'(r_brk_high));
                end
                swu_pkg::PH_BRK_HIGH: begin
                    if (r_brk2) begin
                        n_brk2  = 1'b0;
                        n_phase = swu_pkg::PH_BRK_LOW;
                        n_tick  = swu_pkg::clamp_len(25'(r_brk_low));
                    end else begin
                        n_phase       = swu_pkg::PH_IDLE;
                        n_res.tx_done = 1'b1;
                    end
                end
                default: n_phase = swu_pkg::PH_IDLE;
            endcase
        end

        // Line drive follows the phase after this tick.
        unique case (n_phase)
            swu_pkg::PH_TX_PRE, swu_pkg::PH_TX_STOP, swu_pkg::PH_TX_TAIL,
            swu_pkg::PH_BRK_HIGH: begin
                n_res.line_out   = 1'b1;
                n_res.line_drive = 1'b1;
            end
            swu_pkg::PH_TX_START, swu_pkg::PH_BRK_LOW: begin
                n_res.line_drive = 1'b1;
            end
            swu_pkg::PH_TX_DATA: begin
                n_res.line_out   = n_shift[0];
                n_res.line_drive = 1'b1;
            end
            swu_pkg::PH_TX_PARITY: begin
                n_res.line_out   = n_parity;
                n_res.line_drive = 1'b1;
            end
            default: ;
        endcase
        n_res.busy_res = (n_phase != swu_pkg::PH_IDLE);
    end

    // State and result update on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= swu_pkg::PH_IDLE;
            r_tick   <= '0;
            r_bidx   <= '0;
            r_shift  <= '0;
            r_parity <= 1'b0;
            r_brk2   <= 1'b0;
            r_wait   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_take) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_bidx   <= n_bidx;
                r_shift  <= n_shift;
                r_parity <= n_parity;
                r_brk2   <= n_brk2;
                r_wait   <= n_wait;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.line_out   = r_res.line_out;
    assign o_out.line_drive = r_res.line_drive;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.rx_valid   = r_res.rx_valid;
    assign o_out.rx_byte    = r_res.rx_byte;
    assign o_out.rx_timeout = r_res.rx_timeout;
    assign o_out.tx_done    = r_res.tx_done;

    // The line is never driven by an idle block, and a released line reads low.
    `SWU_ASSERT_ALWAYS(a_idle_released, i_clk, i_rst_n,
        !r_ovalid || r_res.busy_res || !r_res.line_drive)
    `SWU_ASSERT_ALWAYS(a_out_low_released, i_clk, i_rst_n,
        !r_ovalid || r_res.line_drive || !r_res.line_out)
    // A timeout result carries the receive pulse and the fixed byte.
    `SWU_ASSERT_ALWAYS(a_timeout_byte, i_clk, i_rst_n,
        !r_ovalid || !r_res.rx_timeout
        || (r_res.rx_valid && r_res.rx_byte == swu_pkg::RX_TIMEOUT_BYTE))
    // A transmit request taken in idle starts the lead-in phase.
    `SWU_ASSERT_NEXT(a_tx_start, i_clk, i_rst_n,
        in_take && r_phase == swu_pkg::PH_IDLE && i_in.func == swu_pkg::FN_TX,
        r_phase == swu_pkg::PH_TX_PRE && r_res.busy_res)

endmodule
